[design/rom_pkg.sv]
// rom_pkg: widths, reset values and test codes for the rectangle overlap matcher
// no dependencies; used by rect_overlap_match

package rom_pkg;

   // coordinate and extent width of every rectangle field
   localparam int COORD_BITS = 12;

   // right and bottom edges (x + w) need one more bit
   localparam int SUM_BITS   = COORD_BITS + 1;
   // area of one rectangle or of the intersection
   localparam int AREA_BITS  = 2 * COORD_BITS;
   // area of the bounding box of both rectangles
   localparam int UNI_BITS   = 2 * SUM_BITS;
   // scaled areas for the ratio tests: up to ten times an area
   localparam int SCALE_BITS = AREA_BITS + 4;

   // same-rectangle limit register
   localparam int LIMIT_BITS = 24;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(3000);

   // the limit compare runs at the wider of the two widths
   localparam int CMP_BITS = (UNI_BITS > LIMIT_BITS) ? UNI_BITS : LIMIT_BITS;

   // test codes
   localparam int OP_BITS = 3;
   localparam logic [OP_BITS-1:0] OP_QUARTER_SMALL   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_TENTH_B         = 3'd1;
   localparam logic [OP_BITS-1:0] OP_FIFTH_A         = 3'd2;
   localparam logic [OP_BITS-1:0] OP_HALF_SMALL      = 3'd3;
   localparam logic [OP_BITS-1:0] OP_FOUR_FIFTHS     = 3'd4;
   localparam logic [OP_BITS-1:0] OP_SAME_RECT       = 3'd5;

endpackage

[design/rect_overlap_match.sv]
// rect_overlap_match: four-stage pipelined overlap test on two rectangles
// depends on rom_pkg for widths, the limit reset value and the test codes

// usage
//   req_ channel: one word per rectangle pair (opcode, a_x/a_y/a_w/a_h,
//   b_x/b_y/b_w/b_h), taken when req_valid and req_ready are both high
//   rsp_ channel: one word per request, rsp_matched, in request order
//   csr_ channel: writes same_rect_limit (threshold of the same-rect test);
//   csr_ready is always high, write only while no request is in flight
// timing
//   four register stages: edges/spans, products, union/smaller/diff, test
//   rsp_valid rises once the word has been loaded into the test stage register
//   throughput is one word per cycle while rsp_ready stays high;
//   the four products run on parallel multipliers in stage two
// reset
//   synchronous, active high: all stage valid bits clear, the limit
//   register returns to 3000
// stall
//   each stage holds while the one after it is full and not moving;
//   bubbles collapse, so up to four words wait inside while rsp_ready is
//   low and req_ready drops only when every stage is full

module rect_overlap_match (
   input  logic                                clock,
   input  logic                                reset,
   // request words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rom_pkg::OP_BITS-1:0]         req_opcode,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_a_x,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_a_y,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_a_w,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_a_h,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_b_x,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_b_y,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_b_w,
   input  logic [rom_pkg::COORD_BITS-1:0]      req_b_h,
   // response words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_matched,
   // limit register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rom_pkg::LIMIT_BITS-1:0]      csr_same_rect_limit
);

   import rom_pkg::*;

   // stage enables, from the output backwards
   logic en1, en2, en3, en4;

   // limit register
   logic [LIMIT_BITS-1:0] limit_ff;

   // ---------------- stage 1: edges and spans ----------------
   logic [SUM_BITS-1:0]   a_r, a_b, b_r, b_b;
   logic [COORD_BITS-1:0] i_l, i_t, u_l, u_t;
   logic [SUM_BITS-1:0]   i_r, i_bt, u_r, u_bt;
   logic [SUM_BITS-1:0]   iw_full, ih_full;
   logic                  ovl_x, ovl_y;

   logic                  v1_ff;
   logic [OP_BITS-1:0]    op1_ff;
   logic [COORD_BITS-1:0] iw1_ff, ih1_ff, iw1_in, ih1_in;
   logic [COORD_BITS-1:0] aw1_ff, ah1_ff, bw1_ff, bh1_ff;
   logic [SUM_BITS-1:0]   uw1_ff, uh1_ff, uw1_in, uh1_in;
   logic                  ae1_ff, be1_ff;

   // ---------------- stage 2: products ----------------
   logic                  v2_ff;
   logic [OP_BITS-1:0]    op2_ff;
   logic [AREA_BITS-1:0]  inter2_ff, area_a2_ff, area_b2_ff;
   logic [UNI_BITS-1:0]   box2_ff;
   logic                  ae2_ff, be2_ff;

   // ---------------- stage 3: union, smaller, difference ----------------
   logic [UNI_BITS-1:0]   uni3;
   logic                  v3_ff;
   logic [OP_BITS-1:0]    op3_ff;
   logic [AREA_BITS-1:0]  inter3_ff, area_a3_ff, area_b3_ff, small3_ff, small3_in;
   logic [UNI_BITS-1:0]   diff3_ff, diff3_in;

   // ---------------- stage 4: selected test ----------------
   logic [SCALE_BITS-1:0] i_x, s_x, a_x, b_x;
   logic                  t_quarter, t_tenth, t_fifth, t_half, t_four5, t_same;
   logic                  v4_ff;
   logic                  matched4_ff, matched4_in;

   // a stage loads when it is empty or its content moves on
   assign en4       = !v4_ff || rsp_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign csr_ready = 1'b1;

   assign rsp_valid   = v4_ff;
   assign rsp_matched = matched4_ff;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_same_rect_limit;
      end
   end

   // stage 1 logic: intersection spans and bounding box spans
   always_comb begin
      a_r  = SUM_BITS'(req_a_x) + SUM_BITS'(req_a_w);
      a_b  = SUM_BITS'(req_a_y) + SUM_BITS'(req_a_h);
      b_r  = SUM_BITS'(req_b_x) + SUM_BITS'(req_b_w);
      b_b  = SUM_BITS'(req_b_y) + SUM_BITS'(req_b_h);

      i_l  = (req_a_x > req_b_x) ? req_a_x : req_b_x;
      i_t  = (req_a_y > req_b_y) ? req_a_y : req_b_y;
      i_r  = (a_r < b_r) ? a_r : b_r;
      i_bt = (a_b < b_b) ? a_b : b_b;

      u_l  = (req_a_x < req_b_x) ? req_a_x : req_b_x;
      u_t  = (req_a_y < req_b_y) ? req_a_y : req_b_y;
      u_r  = (a_r > b_r) ? a_r : b_r;
      u_bt = (a_b > b_b) ? a_b : b_b;

      ovl_x   = i_r > SUM_BITS'(i_l);
      ovl_y   = i_bt > SUM_BITS'(i_t);
      iw_full = i_r - SUM_BITS'(i_l);
      ih_full = i_bt - SUM_BITS'(i_t);

      // an overlap span never exceeds either width, so it fits a coordinate
      if (ovl_x && ovl_y) begin
         iw1_in = iw_full[COORD_BITS-1:0];
         ih1_in = ih_full[COORD_BITS-1:0];
      end else begin
         iw1_in = '0;
         ih1_in = '0;
      end

      uw1_in = u_r - SUM_BITS'(u_l);
      uh1_in = u_bt - SUM_BITS'(u_t);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff <= req_opcode;
         iw1_ff <= iw1_in;
         ih1_ff <= ih1_in;
         uw1_ff <= uw1_in;
         uh1_ff <= uh1_in;
         aw1_ff <= req_a_w;
         ah1_ff <= req_a_h;
         bw1_ff <= req_b_w;
         bh1_ff <= req_b_h;
         ae1_ff <= (req_a_w == '0) || (req_a_h == '0);
         be1_ff <= (req_b_w == '0) || (req_b_h == '0);
      end
   end

   // stage 2 payload: four parallel products
   always_ff @(posedge clock) begin
      if (en2) begin
         op2_ff     <= op1_ff;
         inter2_ff  <= AREA_BITS'(iw1_ff) * AREA_BITS'(ih1_ff);
         area_a2_ff <= AREA_BITS'(aw1_ff) * AREA_BITS'(ah1_ff);
         area_b2_ff <= AREA_BITS'(bw1_ff) * AREA_BITS'(bh1_ff);
         box2_ff    <= UNI_BITS'(uw1_ff) * UNI_BITS'(uh1_ff);
         ae2_ff     <= ae1_ff;
         be2_ff     <= be1_ff;
      end
   end

   // stage 3 logic: union taken as the bounding box area (empty rectangle yields the other one)
   always_comb begin
      if (ae2_ff) begin
         uni3 = UNI_BITS'(area_b2_ff);
      end else if (be2_ff) begin
         uni3 = UNI_BITS'(area_a2_ff);
      end else begin
         uni3 = box2_ff;
      end
      // the intersection lies inside the union, so this never wraps
      diff3_in  = uni3 - UNI_BITS'(inter2_ff);
      small3_in = (area_a2_ff < area_b2_ff) ? area_a2_ff : area_b2_ff;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         op3_ff     <= op2_ff;
         inter3_ff  <= inter2_ff;
         area_a3_ff <= area_a2_ff;
         area_b3_ff <= area_b2_ff;
         small3_ff  <= small3_in;
         diff3_ff   <= diff3_in;
      end
   end

   // stage 4 logic: i > x / d is the same as d * i > x for truncating division
   always_comb begin
      i_x = SCALE_BITS'(inter3_ff);
      s_x = SCALE_BITS'(small3_ff);
      a_x = SCALE_BITS'(area_a3_ff);
      b_x = SCALE_BITS'(area_b3_ff);

      t_quarter = (i_x << 2) > s_x;
      t_tenth   = ((i_x << 3) + (i_x << 1)) > b_x;
      t_fifth   = ((i_x << 2) + i_x) > a_x;
      t_half    = (i_x << 1) > s_x;
      t_four5   = ((i_x << 2) + i_x) > (s_x << 2);
      t_same    = CMP_BITS'(diff3_ff) < CMP_BITS'(limit_ff);

      unique case (op3_ff)
         OP_QUARTER_SMALL: matched4_in = t_quarter;
         OP_TENTH_B:       matched4_in = t_tenth;
         OP_FIFTH_A:       matched4_in = t_fifth;
         OP_HALF_SMALL:    matched4_in = t_half;
         OP_FOUR_FIFTHS:   matched4_in = t_four5;
         OP_SAME_RECT:     matched4_in = t_same;
         // unused codes never match
         default:          matched4_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         matched4_ff <= matched4_in;
      end
   end

endmodule
